// File: rtl/bounded_deque_remove_by_key_unit_defines.svh
// Assertion macros used by the deque unit's sequencer.
`ifndef BOUNDED_DEQUE_REMOVE_BY_KEY_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_REMOVE_BY_KEY_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// Package with the deque unit's widths, request and status codes, and shared types.
`default_nettype none

package bdq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bdq_req_if.sv
// Request channel interface: one word carries a request kind and a value or key.
`default_nettype none

interface bdq_req_if;

    logic                         valid;
    logic                         ready;
    logic [bdq_pkg::KIND_W-1:0]   kind;
    logic [bdq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

`default_nettype wire

// File: rtl/bdq_rsp_if.sv
// Response channel interface: one word carries status, removed value and entry count.
`default_nettype none

interface bdq_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::STATUS_W-1:0]  status;
    logic [bdq_pkg::VALUE_W-1:0]   taken_value;
    logic [bdq_pkg::COUNT_W-1:0]   entry_count;

    modport source (output valid, output status, output taken_value, output entry_count,
                     input ready);
    modport sink   (input valid, input status, input taken_value, input entry_count,
                     output ready);

endinterface

`default_nettype wire

// File: rtl/bdq_store.sv
// Entry memory with a registered read port and the shared key comparator.
`default_nettype none

module bdq_store #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF,
    parameter int DATA_W   = bdq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire bdq_pkg::store_ctl_t         ctl,
    input  wire logic [$clog2(CAPACITY)-1:0] waddr,
    input  wire logic [DATA_W-1:0]           wdata,
    input  wire logic [$clog2(CAPACITY)-1:0] raddr,
    input  wire logic [DATA_W-1:0]           key,
    output      logic [DATA_W-1:0]           rdata,
    output      logic                        match
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign match = (rdata_reg == key);

endmodule

`default_nettype wire

// File: rtl/bdq_seq.sv
// Sequencer that executes each request, walks the ring for removal by key, and holds the response register.
`default_nettype none

`include "bounded_deque_remove_by_key_unit_defines.svh"

module bdq_seq #(
    parameter int CAPACITY    = bdq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bdq_req_if.sink                          req,
    bdq_rsp_if.source                        rsp,
    output      bdq_pkg::store_ctl_t         st_ctl,
    output      logic [$clog2(CAPACITY)-1:0] st_waddr,
    output      logic [((VALUE_WIDTH < bdq_pkg::VALUE_W) ? VALUE_WIDTH
                        : bdq_pkg::VALUE_W)-1:0] st_wdata,
    output      logic [$clog2(CAPACITY)-1:0] st_raddr,
    output      logic [((VALUE_WIDTH < bdq_pkg::VALUE_W) ? VALUE_WIDTH
                        : bdq_pkg::VALUE_W)-1:0] st_key,
    input  wire logic [((VALUE_WIDTH < bdq_pkg::VALUE_W) ? VALUE_WIDTH
                        : bdq_pkg::VALUE_W)-1:0] st_rdata,
    input  wire logic                        st_match
);

    localparam int SW   = (VALUE_WIDTH < bdq_pkg::VALUE_W) ? VALUE_WIDTH : bdq_pkg::VALUE_W;
    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SUMW = AW + 1;
    localparam int VW   = bdq_pkg::VALUE_W;
    localparam int OW   = bdq_pkg::COUNT_W;
    localparam int KW   = bdq_pkg::KIND_W;
    localparam int STW  = bdq_pkg::STATUS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
    endfunction

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           out_valid_reg, out_valid_next;

    logic [KW-1:0]  kind_reg, kind_next;
    logic [SW-1:0]  key_reg, key_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [STW-1:0] status_reg, status_next;
    logic [SW-1:0]  taken_reg, taken_next;
    logic [STW-1:0] out_status_reg, out_status_next;
    logic [VW-1:0]  out_taken_reg, out_taken_next;
    logic [OW-1:0]  out_count_reg, out_count_next;

    logic            full;
    logic            empty;
    logic            out_free;
    logic [SUMW-1:0] tail_sum;
    logic [AW-1:0]   tail;

    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign out_free = !out_valid_reg || rsp.ready;
    assign tail_sum = SUMW'(head_reg) + SUMW'(count_reg);
    assign tail     = (tail_sum >= SUMW'(CAPACITY)) ? AW'(tail_sum - SUMW'(CAPACITY))
                                                    : AW'(tail_sum);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.taken_value = out_taken_reg;
    assign rsp.entry_count = out_count_reg;
    assign st_key          = key_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        rd_ptr_next     = rd_ptr_reg;
        rem_next        = rem_reg;
        status_next     = status_reg;
        taken_next      = taken_reg;
        out_status_next = out_status_reg;
        out_taken_next  = out_taken_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        st_ctl          = '0;
        st_waddr        = pos_reg;
        st_wdata        = key_reg;
        st_raddr        = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    key_next   = SW'(req.value);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = bdq_pkg::ST_OK;
                taken_next  = '0;
                state_next  = S_DONE;
                case (kind_reg)
                    bdq_pkg::KIND_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            st_ctl.wr_en = 1'b1;
                            st_waddr     = ring_dec(head_reg);
                            head_next    = ring_dec(head_reg);
                            count_next   = count_reg + CW'(1);
                        end
                    end
                    bdq_pkg::KIND_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            st_ctl.wr_en = 1'b1;
                            st_waddr     = tail;
                            count_next   = count_reg + CW'(1);
                        end
                    end
                    bdq_pkg::KIND_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            st_ctl.rd_en = 1'b1;
                            st_raddr     = head_reg;
                            state_next   = S_POP;
                        end
                    end
                    bdq_pkg::KIND_REMOVE:
                    begin
                        if (empty)
                        begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            st_ctl.rd_en = 1'b1;
                            st_raddr     = head_reg;
                            pos_next     = head_reg;
                            rem_next     = count_reg - CW'(1);
                            state_next   = S_SCAN;
                        end
                    end
                    default:
                    begin
                        status_next = bdq_pkg::ST_OK;
                    end
                endcase
            end
            S_POP:
            begin
                taken_next = st_rdata;
                head_next  = ring_inc(head_reg);
                count_next = count_reg - CW'(1);
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // The next entry is fetched ahead so a hit can start shifting at once.
                st_ctl.rd_en = 1'b1;
                st_raddr     = ring_inc(pos_reg);
                if (st_match)
                begin
                    taken_next = st_rdata;
                    if (rem_reg != '0)
                    begin
                        rd_ptr_next = ring_inc(pos_reg);
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end
                else if (rem_reg == '0)
                begin
                    status_next = bdq_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    pos_next = ring_inc(pos_reg);
                    rem_next = rem_reg - CW'(1);
                end
            end
            S_SHIFT:
            begin
                st_ctl.wr_en = 1'b1;
                st_waddr     = pos_reg;
                st_wdata     = st_rdata;
                st_ctl.rd_en = 1'b1;
                st_raddr     = ring_inc(rd_ptr_reg);
                pos_next     = rd_ptr_reg;
                rd_ptr_next  = ring_inc(rd_ptr_reg);
                rem_next     = rem_reg - CW'(1);
                if (rem_reg == CW'(1))
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_taken_next  = VW'(taken_reg);
                    out_count_next  = OW'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        rd_ptr_reg     <= rd_ptr_next;
        rem_reg        <= rem_next;
        status_reg     <= status_next;
        taken_reg      <= taken_next;
        out_status_reg <= out_status_next;
        out_taken_reg  <= out_taken_next;
        out_count_reg  <= out_count_next;
    end

    `BDQ_ASSERT_NEXT(a_accept_starts, (state_reg == S_IDLE) && req.valid,
        state_reg == S_EXEC, "accepted request did not start execution")
    `BDQ_ASSERT_NOW(a_shift_has_work, state_reg == S_SHIFT,
        rem_reg != '0, "shift step entered with nothing left to move")
    `BDQ_ASSERT_NOW(a_count_moves_in_work, count_reg != $past(count_reg),
        ($past(state_reg) == S_EXEC) || ($past(state_reg) == S_POP) ||
        ($past(state_reg) == S_SCAN) || ($past(state_reg) == S_SHIFT),
        "entry count changed outside a working state")
    `BDQ_ASSERT_NOW(a_out_from_done, $rose(out_valid_reg),
        $past(state_reg) == S_DONE, "response word loaded outside the done state")

endmodule

`default_nettype wire

// File: rtl/bounded_deque_remove_by_key_unit.sv
// Each request passes an execute state and then a done state that loads the response register.
// Pop adds a read state; remove by key scans entries, then shifts those behind the hit, one per cycle.
// Requests are served one at a time over the single memory port pair; a new one is taken only when idle.
// The response register lets the next request be accepted while a response waits.
// Reset clears the entry count, the head position and the response valid at once.
// Entry contents are not cleared and need no clearing pass.
`default_nettype none

module bounded_deque_remove_by_key_unit #(
    parameter int CAPACITY    = bdq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    localparam int SW = (VALUE_WIDTH < bdq_pkg::VALUE_W) ? VALUE_WIDTH : bdq_pkg::VALUE_W;
    localparam int AW = $clog2(CAPACITY);

    bdq_pkg::store_ctl_t st_ctl;
    logic [AW-1:0]       st_waddr;
    logic [SW-1:0]       st_wdata;
    logic [AW-1:0]       st_raddr;
    logic [SW-1:0]       st_key;
    logic [SW-1:0]       st_rdata;
    logic                st_match;

    bdq_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .st_ctl   (st_ctl),
        .st_waddr (st_waddr),
        .st_wdata (st_wdata),
        .st_raddr (st_raddr),
        .st_key   (st_key),
        .st_rdata (st_rdata),
        .st_match (st_match)
    );

    bdq_store #(
        .CAPACITY (CAPACITY),
        .DATA_W   (SW)
    ) u_store (
        .clk   (clk),
        .ctl   (st_ctl),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .key   (st_key),
        .rdata (st_rdata),
        .match (st_match)
    );

endmodule

`default_nettype wire

// File: bench/tb_bounded_deque_remove_by_key_unit.sv
// Self-checking testbench for the bounded deque unit with removal by key.
module tb_bounded_deque_remove_by_key_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP    = bdq_pkg::CAPACITY_DEF;
    localparam int CAP_AW = $clog2(CAP);

    typedef struct packed {
        logic [bdq_pkg::KIND_W-1:0]  kind;
        logic [bdq_pkg::VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [bdq_pkg::STATUS_W-1:0] status;
        logic [bdq_pkg::VALUE_W-1:0]  taken;
        logic [bdq_pkg::COUNT_W-1:0]  count;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bdq_req_if req_bus ();
    bdq_rsp_if rsp_bus ();

    bounded_deque_remove_by_key_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    request_t                    pending_words[$];
    outcome_t                    expected_outcomes[$];
    logic [bdq_pkg::VALUE_W-1:0] mirror [CAP];
    int unsigned                 front_pos      = 0;
    int unsigned                 depth          = 0;
    int unsigned                 queued_total   = 0;
    int unsigned                 accepted_total = 0;
    int unsigned                 checked_total  = 0;
    int unsigned                 mismatches     = 0;
    int unsigned                 send_gap;
    int unsigned                 recv_stall;
    logic                        hold_responses = 1'b0;
    logic                        tail_mode      = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [CAP_AW-1:0] ring_slot(input int unsigned offset);
        return CAP_AW'((front_pos + offset) % CAP);
    endfunction

    task automatic deque_apply(input logic [bdq_pkg::KIND_W-1:0] op,
                               input logic [bdq_pkg::VALUE_W-1:0] word,
                               output outcome_t res);
        int unsigned hit;
        res.status = bdq_pkg::ST_OK;
        res.taken  = '0;
        case (op)
            bdq_pkg::KIND_PUSH_FRONT:
                if (depth >= CAP)
                begin
                    res.status = bdq_pkg::ST_FULL;
                end
                else
                begin
                    front_pos = (front_pos + CAP - 1) % CAP;
                    mirror[ring_slot(0)] = word;
                    depth++;
                end
            bdq_pkg::KIND_PUSH_BACK:
                if (depth >= CAP)
                begin
                    res.status = bdq_pkg::ST_FULL;
                end
                else
                begin
                    mirror[ring_slot(depth)] = word;
                    depth++;
                end
            bdq_pkg::KIND_POP_FRONT:
                if (depth == 0)
                begin
                    res.status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.taken = mirror[ring_slot(0)];
                    front_pos = (front_pos + 1) % CAP;
                    depth--;
                end
            bdq_pkg::KIND_REMOVE:
                if (depth == 0)
                begin
                    res.status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    hit = depth;
                    for (int unsigned i = 0; i < depth; i++)
                    begin
                        if (hit == depth && mirror[ring_slot(i)] == word)
                        begin
                            hit = i;
                        end
                    end
                    if (hit == depth)
                    begin
                        res.status = bdq_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        res.taken = mirror[ring_slot(hit)];
                        for (int unsigned i = hit; i + 1 < depth; i++)
                        begin
                            mirror[ring_slot(i)] = mirror[ring_slot(i + 1)];
                        end
                        depth--;
                    end
                end
            default:
            begin
                res.status = bdq_pkg::ST_OK;
            end
        endcase
        res.count = depth[bdq_pkg::COUNT_W-1:0];
    endtask

    task automatic report_mismatch(input string field, input logic [bdq_pkg::VALUE_W-1:0] want,
                                   input logic [bdq_pkg::VALUE_W-1:0] got);
        $display("mismatch at %0t on %s: expected %0h, got %0h", $realtime, field, want, got);
        mismatches++;
    endtask

    task automatic queue_word(input logic [bdq_pkg::KIND_W-1:0] op,
                              input logic [bdq_pkg::VALUE_W-1:0] word);
        request_t item;
        item.kind  = op;
        item.value = word;
        pending_words.push_back(item);
        queued_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        request_t item;
        outcome_t predicted;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.kind  <= '0;
            req_bus.value <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                deque_apply(req_bus.kind, req_bus.value, predicted);
                expected_outcomes.push_back(predicted);
                accepted_total++;
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    item = pending_words.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.kind  <= item.kind;
                    req_bus.value <= item.value;
                    if (!tail_mode && $urandom_range(0, 9) == 0)
                    begin
                        send_gap <= $urandom_range(1, 18);
                    end
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            recv_stall    <= 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    report_mismatch("word with nothing expected", '0, rsp_bus.taken_value);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (rsp_bus.status !== want.status)
                    begin
                        report_mismatch("status", bdq_pkg::VALUE_W'(want.status),
                                        bdq_pkg::VALUE_W'(rsp_bus.status));
                    end
                    if (rsp_bus.taken_value !== want.taken)
                    begin
                        report_mismatch("taken_value", want.taken, rsp_bus.taken_value);
                    end
                    if (rsp_bus.entry_count !== want.count)
                    begin
                        report_mismatch("entry_count", bdq_pkg::VALUE_W'(want.count),
                                        bdq_pkg::VALUE_W'(rsp_bus.entry_count));
                    end
                end
                checked_total++;
            end
            if (hold_responses)
            begin
                rsp_bus.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall    <= recv_stall - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (!tail_mode && $urandom_range(0, 11) == 0)
                begin
                    recv_stall <= $urandom_range(1, 18);
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (accepted_total < 400)
        begin
            @(posedge clk);
        end
        hold_responses <= 1'b1;
        repeat (400) @(posedge clk);
        hold_responses <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_bounded_deque_remove_by_key_unit: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [bdq_pkg::VALUE_W-1:0] pool [8];
        logic [bdq_pkg::KIND_W-1:0]  op;
        logic [bdq_pkg::VALUE_W-1:0] word;
        int unsigned                 push_share;
        int unsigned                 roll;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        queue_word(bdq_pkg::KIND_POP_FRONT, '0);
        queue_word(bdq_pkg::KIND_REMOVE, '0);
        queue_word(bdq_pkg::KIND_PUSH_FRONT, '0);
        queue_word(bdq_pkg::KIND_PUSH_BACK, '1);
        queue_word(bdq_pkg::KIND_REMOVE, 32'h1234_5678);
        queue_word(bdq_pkg::KIND_REMOVE, '1);
        queue_word(bdq_pkg::KIND_POP_FRONT, '0);
        for (int i = 0; i < CAP; i++)
        begin
            queue_word((i % 2 == 0) ? bdq_pkg::KIND_PUSH_FRONT : bdq_pkg::KIND_PUSH_BACK,
                       {16'hC0DE, 16'(i % 5)});
        end
        queue_word(bdq_pkg::KIND_PUSH_FRONT, 32'hDEAD_BEEF);
        queue_word(bdq_pkg::KIND_PUSH_BACK, 32'hDEAD_BEEF);
        queue_word(bdq_pkg::KIND_REMOVE, {16'hC0DE, 16'd2});
        queue_word(bdq_pkg::KIND_POP_FRONT, '0);
        queue_word(bdq_pkg::KIND_REMOVE, '0);

        while (checked_total != queued_total)
        begin
            @(posedge clk);
        end

        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < 8; i++)
        begin
            pool[3'(i)] = $urandom;
        end
        for (int seg = 0; seg < 48; seg++)
        begin
            push_share = $urandom_range(15, 85);
            for (int n = 0; n < 40; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_share)
                begin
                    op = ($urandom_range(0, 1) == 0) ? bdq_pkg::KIND_PUSH_FRONT
                                                     : bdq_pkg::KIND_PUSH_BACK;
                end
                else
                begin
                    op = ($urandom_range(0, 2) == 0) ? bdq_pkg::KIND_POP_FRONT
                                                     : bdq_pkg::KIND_REMOVE;
                end
                word = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : pool[3'($urandom_range(0, 7))];
                queue_word(op, word);
            end
        end

        while (pending_words.size() > 150)
        begin
            @(posedge clk);
        end
        tail_mode <= 1'b1;
        while (pending_words.size() != 0 || checked_total != queued_total)
        begin
            @(posedge clk);
        end
        repeat (CAP + 16) @(posedge clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
        begin
            $display("tb_bounded_deque_remove_by_key_unit: PASS");
        end
        else
        begin
            $display("tb_bounded_deque_remove_by_key_unit: FAIL");
        end
        $finish;
    end

endmodule
